// File: hdl/mpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpe_pkg
// Types, widths and constants shared by the escape-time pixel unit.
// ----------------------------------------------------------------------------
package mpe_pkg;

	localparam int COORD_BITS    = 32;
	localparam int FRACTION_BITS = 28;
	localparam int PIXEL_BITS    = 12;
	localparam int COUNT_BITS    = 16;
	localparam int SIZE_BITS     = 13;
	localparam int PROD_BITS     = COORD_BITS + PIXEL_BITS;
	localparam int DIV_CNT_BITS  = $clog2(PROD_BITS);
	localparam int SQ_BITS       = 2 * COORD_BITS;
	localparam int ADDR_BITS     = 5;
	localparam int DATA_BITS     = 32;
	localparam int REG_IDX_BITS  = 3;

	localparam logic [SQ_BITS-1:0] ESC_LIMIT = SQ_BITS'(1) << (2 * FRACTION_BITS + 2);

	localparam logic [REG_IDX_BITS-1:0] REG_REAL_LOW   = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_REAL_HIGH  = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_IMAG_LOW   = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_IMAG_HIGH  = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_W    = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_H    = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_MAX_ITER   = 3'd6;

	localparam logic [COORD_BITS-1:0] RST_REAL_LOW  = 32'hE000_0000;
	localparam logic [COORD_BITS-1:0] RST_REAL_HIGH = 32'h1000_0000;
	localparam logic [COORD_BITS-1:0] RST_IMAG_LOW  = 32'hE800_0000;
	localparam logic [COORD_BITS-1:0] RST_IMAG_HIGH = 32'h1800_0000;
	localparam logic [SIZE_BITS-1:0]  RST_IMAGE_W   = 13'd800;
	localparam logic [SIZE_BITS-1:0]  RST_IMAGE_H   = 13'd800;
	localparam logic [COUNT_BITS-1:0] RST_MAX_ITER  = 16'd600;

	localparam logic [7:0] RED_MUL   = 8'd9;
	localparam logic [7:0] GREEN_MUL = 8'd5;
	localparam logic [7:0] BLUE_MUL  = 8'd3;
	localparam logic [7:0] ALPHA     = 8'hFF;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel_col;
		logic [PIXEL_BITS-1:0] pixel_row;
	} pix_req_t;

	typedef struct packed {
		logic [31:0]           rgba_color;
		logic [COUNT_BITS-1:0] iteration_count;
		logic                  escaped;
	} pix_rsp_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] low;
		logic [COORD_BITS-1:0] high;
		logic [PIXEL_BITS-1:0] pixel;
		logic [SIZE_BITS-1:0]  size;
	} map_req_t;

	typedef struct packed {
		logic start;
		logic take;
	} iter_ctl_t;

	typedef struct packed {
		logic                  done;
		logic [COUNT_BITS-1:0] count;
		logic                  escaped;
	} iter_stat_t;

	typedef enum logic [1:0] {
		MAP_IDLE,
		MAP_MUL,
		MAP_DIV,
		MAP_DONE
	} map_state_t;

	typedef enum logic [2:0] {
		IT_IDLE,
		IT_SQ_R,
		IT_SQ_I,
		IT_CROSS,
		IT_STEP,
		IT_DONE
	} iter_state_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_MAP_RE,
		TOP_MAP_IM,
		TOP_ITER
	} top_state_t;

	function automatic logic [31:0] make_color(input logic [COUNT_BITS-1:0] count,
	                                           input logic escaped);
		logic [7:0] c8;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		c8 = count[7:0];
		r  = 8'(c8 * RED_MUL);
		g  = 8'(c8 * GREEN_MUL);
		b  = 8'(c8 * BLUE_MUL);
		if (escaped) begin
			make_color = {r, g, b, ALPHA};
		end else begin
			make_color = {24'd0, ALPHA};
		end
	endfunction

endpackage
`default_nettype wire

// File: hdl/mandelbrot_pixel_escape_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_pixel_escape_unit
// Maps a pixel to a point of the view window and returns its escape count
// and color.
// ----------------------------------------------------------------------------
//  channel   | signals                              | moves
//  ----------+--------------------------------------+---------------------------
//  request   | req_valid, req_ready, req            | pixel column and row
//  response  | rsp_valid, rsp_ready, rsp            | color, count, escaped flag
//  config    | psel, penable, pwrite, paddr, pwdata,| view window, image size,
//            | prdata, pready                       | iteration limit
//
//  Each axis runs a 44-bit bit-serial divide, skipped for a zero image size,
//  and each step runs its products on the iterator's one shared 32x32
//  multiplier, through the states SQ_R, SQ_I, CROSS and STEP. Reset loads
//  the default view.
//  A new request is taken while a response waits; a stalled response holds
//  the next result in the iterator.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_escape_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            req_valid,
	output logic                           req_ready,
	input  mpe_pkg::pix_req_t              req,
	output logic                           rsp_valid,
	input  wire                            rsp_ready,
	output mpe_pkg::pix_rsp_t              rsp,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [mpe_pkg::ADDR_BITS-1:0]   paddr,
	input  wire [mpe_pkg::DATA_BITS-1:0]   pwdata,
	output logic [mpe_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready
);

	mpe_pkg::top_state_t state_q;
	mpe_pkg::top_state_t state_d;

	logic [mpe_pkg::COORD_BITS-1:0] real_low_q;
	logic [mpe_pkg::COORD_BITS-1:0] real_high_q;
	logic [mpe_pkg::COORD_BITS-1:0] imag_low_q;
	logic [mpe_pkg::COORD_BITS-1:0] imag_high_q;
	logic [mpe_pkg::SIZE_BITS-1:0]  image_width_q;
	logic [mpe_pkg::SIZE_BITS-1:0]  image_height_q;
	logic [mpe_pkg::COUNT_BITS-1:0] max_iter_q;

	logic [mpe_pkg::PIXEL_BITS-1:0] row_q;
	logic [mpe_pkg::COORD_BITS-1:0] cr_q;
	logic                           rsp_valid_q;
	mpe_pkg::pix_rsp_t              rsp_q;

	logic                              cfg_wr;
	logic [mpe_pkg::REG_IDX_BITS-1:0]  reg_idx;
	logic                              req_fire;
	logic                              map_start;
	mpe_pkg::map_req_t                 map_op;
	logic                              map_done;
	logic [mpe_pkg::COORD_BITS-1:0]    map_coord;
	mpe_pkg::iter_ctl_t                it_ctl;
	mpe_pkg::iter_stat_t               it_stat;
	logic                              rsp_free;
	logic                              rsp_load;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[mpe_pkg::ADDR_BITS-1:2];

	always_comb begin
		unique case (reg_idx)
			mpe_pkg::REG_REAL_LOW:  prdata = real_low_q;
			mpe_pkg::REG_REAL_HIGH: prdata = real_high_q;
			mpe_pkg::REG_IMAG_LOW:  prdata = imag_low_q;
			mpe_pkg::REG_IMAG_HIGH: prdata = imag_high_q;
			mpe_pkg::REG_IMAGE_W:   prdata = mpe_pkg::DATA_BITS'(image_width_q);
			mpe_pkg::REG_IMAGE_H:   prdata = mpe_pkg::DATA_BITS'(image_height_q);
			mpe_pkg::REG_MAX_ITER:  prdata = mpe_pkg::DATA_BITS'(max_iter_q);
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_low_q     <= mpe_pkg::RST_REAL_LOW;
			real_high_q    <= mpe_pkg::RST_REAL_HIGH;
			imag_low_q     <= mpe_pkg::RST_IMAG_LOW;
			imag_high_q    <= mpe_pkg::RST_IMAG_HIGH;
			image_width_q  <= mpe_pkg::RST_IMAGE_W;
			image_height_q <= mpe_pkg::RST_IMAGE_H;
			max_iter_q     <= mpe_pkg::RST_MAX_ITER;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				mpe_pkg::REG_REAL_LOW:  real_low_q     <= pwdata;
				mpe_pkg::REG_REAL_HIGH: real_high_q    <= pwdata;
				mpe_pkg::REG_IMAG_LOW:  imag_low_q     <= pwdata;
				mpe_pkg::REG_IMAG_HIGH: imag_high_q    <= pwdata;
				mpe_pkg::REG_IMAGE_W:   image_width_q  <= pwdata[mpe_pkg::SIZE_BITS-1:0];
				mpe_pkg::REG_IMAGE_H:   image_height_q <= pwdata[mpe_pkg::SIZE_BITS-1:0];
				mpe_pkg::REG_MAX_ITER:  max_iter_q     <= pwdata[mpe_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpe_pkg::TOP_IDLE: begin
				if (req_valid) state_d = mpe_pkg::TOP_MAP_RE;
			end
			mpe_pkg::TOP_MAP_RE: begin
				if (map_done) state_d = mpe_pkg::TOP_MAP_IM;
			end
			mpe_pkg::TOP_MAP_IM: begin
				if (map_done) state_d = mpe_pkg::TOP_ITER;
			end
			mpe_pkg::TOP_ITER: begin
				if (it_stat.done && rsp_free) state_d = mpe_pkg::TOP_IDLE;
			end
			default: state_d = mpe_pkg::TOP_IDLE;
		endcase
	end

	always_comb begin
		req_ready    = state_q == mpe_pkg::TOP_IDLE;
		req_fire     = req_valid && req_ready;
		rsp_free     = !rsp_valid_q || rsp_ready;
		map_start    = req_fire || (state_q == mpe_pkg::TOP_MAP_RE && map_done);
		it_ctl.start = state_q == mpe_pkg::TOP_MAP_IM && map_done;
		it_ctl.take  = state_q == mpe_pkg::TOP_ITER && rsp_free;
		rsp_load     = state_q == mpe_pkg::TOP_ITER && it_stat.done && rsp_free;
		if (state_q == mpe_pkg::TOP_IDLE) begin
			map_op.low   = real_low_q;
			map_op.high  = real_high_q;
			map_op.pixel = req.pixel_col;
			map_op.size  = image_width_q;
		end else begin
			map_op.low   = imag_low_q;
			map_op.high  = imag_high_q;
			map_op.pixel = row_q;
			map_op.size  = image_height_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpe_pkg::TOP_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			row_q <= req.pixel_row;
		end
		if (state_q == mpe_pkg::TOP_MAP_RE && map_done) begin
			cr_q <= map_coord;
		end
		if (rsp_load) begin
			rsp_q.rgba_color      <= mpe_pkg::make_color(it_stat.count, it_stat.escaped);
			rsp_q.iteration_count <= it_stat.count;
			rsp_q.escaped         <= it_stat.escaped;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	mpe_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (map_start),
		.op     (map_op),
		.done   (map_done),
		.coord  (map_coord)
	);

	mpe_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (it_ctl),
		.cr     (cr_q),
		.ci     (map_coord),
		.limit  (max_iter_q),
		.stat   (it_stat)
	);

endmodule
`default_nettype wire

// File: hdl/mpe_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpe_map
// Pixel-to-coordinate mapper: one product, then a bit-serial restoring divide, skipped for a zero size.
// ----------------------------------------------------------------------------
module mpe_map (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  mpe_pkg::map_req_t               op,
	output logic                            done,
	output logic [mpe_pkg::COORD_BITS-1:0]  coord
);

	mpe_pkg::map_state_t state_q;
	mpe_pkg::map_state_t state_d;

	logic [mpe_pkg::COORD_BITS-1:0]   low_q;
	logic [mpe_pkg::COORD_BITS-1:0]   mag_q;
	logic [mpe_pkg::PIXEL_BITS-1:0]   pixel_q;
	logic [mpe_pkg::SIZE_BITS-1:0]    size_q;
	logic                             neg_q;
	logic [mpe_pkg::PROD_BITS-1:0]    quo_q;
	logic [mpe_pkg::SIZE_BITS-1:0]    rem_q;
	logic [mpe_pkg::DIV_CNT_BITS-1:0] cnt_q;

	logic [mpe_pkg::COORD_BITS-1:0] span;
	logic [mpe_pkg::SIZE_BITS:0]    trial;
	logic [mpe_pkg::SIZE_BITS:0]    diff;
	logic                           fits;
	logic [mpe_pkg::COORD_BITS-1:0] offset;
	logic                           take_op;

	assign span  = op.high - op.low;
	assign trial = {rem_q, quo_q[mpe_pkg::PROD_BITS-1]};
	assign diff  = trial - {1'b0, size_q};
	assign fits  = trial >= {1'b0, size_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpe_pkg::MAP_IDLE: begin
				if (start) state_d = mpe_pkg::MAP_MUL;
			end
			mpe_pkg::MAP_MUL: begin
				state_d = (size_q == '0) ? mpe_pkg::MAP_DONE : mpe_pkg::MAP_DIV;
			end
			mpe_pkg::MAP_DIV: begin
				if (cnt_q == '0) state_d = mpe_pkg::MAP_DONE;
			end
			mpe_pkg::MAP_DONE: begin
				state_d = start ? mpe_pkg::MAP_MUL : mpe_pkg::MAP_IDLE;
			end
			default: state_d = mpe_pkg::MAP_IDLE;
		endcase
	end

	always_comb begin
		take_op = start && (state_q == mpe_pkg::MAP_IDLE || state_q == mpe_pkg::MAP_DONE);
		done    = state_q == mpe_pkg::MAP_DONE;
		offset  = neg_q ? -quo_q[mpe_pkg::COORD_BITS-1:0] : quo_q[mpe_pkg::COORD_BITS-1:0];
		coord   = (size_q == '0) ? low_q : low_q + offset;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpe_pkg::MAP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_op) begin
			low_q   <= op.low;
			mag_q   <= span[mpe_pkg::COORD_BITS-1] ? -span : span;
			neg_q   <= span[mpe_pkg::COORD_BITS-1];
			pixel_q <= op.pixel;
			size_q  <= op.size;
		end
		if (state_q == mpe_pkg::MAP_MUL) begin
			quo_q <= mpe_pkg::PROD_BITS'(mag_q) * mpe_pkg::PROD_BITS'(pixel_q);
			rem_q <= '0;
			cnt_q <= mpe_pkg::DIV_CNT_BITS'(mpe_pkg::PROD_BITS - 1);
		end else if (state_q == mpe_pkg::MAP_DIV) begin
			quo_q <= {quo_q[mpe_pkg::PROD_BITS-2:0], fits};
			rem_q <= fits ? diff[mpe_pkg::SIZE_BITS-1:0] : trial[mpe_pkg::SIZE_BITS-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: hdl/mpe_iter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpe_iter
// Escape-time iterator around one shared signed multiplier; each step runs the states SQ_R, SQ_I, CROSS and STEP.
// ----------------------------------------------------------------------------
module mpe_iter (
	input  wire                             clk,
	input  wire                             arst_n,
	input  mpe_pkg::iter_ctl_t              ctl,
	input  wire [mpe_pkg::COORD_BITS-1:0]   cr,
	input  wire [mpe_pkg::COORD_BITS-1:0]   ci,
	input  wire [mpe_pkg::COUNT_BITS-1:0]   limit,
	output mpe_pkg::iter_stat_t             stat
);

	mpe_pkg::iter_state_t state_q;
	mpe_pkg::iter_state_t state_d;

	logic [mpe_pkg::COORD_BITS-1:0]        zr_q;
	logic [mpe_pkg::COORD_BITS-1:0]        zi_q;
	logic [mpe_pkg::COORD_BITS-1:0]        cr_q;
	logic [mpe_pkg::COORD_BITS-1:0]        ci_q;
	logic [mpe_pkg::COUNT_BITS-1:0]        limit_q;
	logic [mpe_pkg::COUNT_BITS-1:0]        count_q;
	logic signed [mpe_pkg::SQ_BITS-1:0]    prod_q;
	logic [mpe_pkg::SQ_BITS-1:0]           rr_q;
	logic [mpe_pkg::SQ_BITS-1:0]           ii_q;

	logic signed [mpe_pkg::COORD_BITS-1:0] mul_a;
	logic signed [mpe_pkg::COORD_BITS-1:0] mul_b;
	logic [mpe_pkg::SQ_BITS-1:0]           sq_sum;
	logic                                  outside;

	assign sq_sum  = rr_q + mpe_pkg::SQ_BITS'(prod_q);
	assign outside = sq_sum >= mpe_pkg::ESC_LIMIT;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mpe_pkg::IT_IDLE: begin
				if (ctl.start) state_d = mpe_pkg::IT_SQ_R;
			end
			mpe_pkg::IT_SQ_R: begin
				state_d = (count_q < limit_q) ? mpe_pkg::IT_SQ_I : mpe_pkg::IT_DONE;
			end
			mpe_pkg::IT_SQ_I: begin
				state_d = mpe_pkg::IT_CROSS;
			end
			mpe_pkg::IT_CROSS: begin
				state_d = outside ? mpe_pkg::IT_DONE : mpe_pkg::IT_STEP;
			end
			mpe_pkg::IT_STEP: begin
				state_d = mpe_pkg::IT_SQ_R;
			end
			mpe_pkg::IT_DONE: begin
				if (ctl.take) state_d = mpe_pkg::IT_IDLE;
			end
			default: state_d = mpe_pkg::IT_IDLE;
		endcase
	end

	always_comb begin
		mul_a = zr_q;
		mul_b = zr_q;
		unique case (state_q)
			mpe_pkg::IT_SQ_I: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			mpe_pkg::IT_CROSS: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
		endcase
		stat.done    = state_q == mpe_pkg::IT_DONE;
		stat.count   = count_q;
		stat.escaped = count_q != limit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpe_pkg::IT_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == mpe_pkg::IT_IDLE && ctl.start) begin
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
			cr_q    <= cr;
			ci_q    <= ci;
			limit_q <= limit;
		end
		if (state_q == mpe_pkg::IT_SQ_I) begin
			rr_q <= mpe_pkg::SQ_BITS'(prod_q);
		end
		if (state_q == mpe_pkg::IT_CROSS) begin
			ii_q <= mpe_pkg::SQ_BITS'(prod_q);
		end
		if (state_q == mpe_pkg::IT_STEP) begin
			zr_q    <= rr_q[mpe_pkg::FRACTION_BITS +: mpe_pkg::COORD_BITS]
			         - ii_q[mpe_pkg::FRACTION_BITS +: mpe_pkg::COORD_BITS] + cr_q;
			zi_q    <= prod_q[mpe_pkg::FRACTION_BITS-1 +: mpe_pkg::COORD_BITS] + ci_q;
			count_q <= count_q + 1'b1;
		end
	end

endmodule
`default_nettype wire
